// ===== rtl/msb_pkg.sv =====
// Shared types and constants of the masked sprite blitter.
`timescale 1ns / 1ps

package msb_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DEST_X    = 3'd0;
  localparam logic [2:0] REG_DEST_Y    = 3'd1;
  localparam logic [2:0] REG_ROW_BYTES = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT = 3'd3;
  localparam logic [2:0] REG_USE_MASK  = 3'd4;

  // Largest row length in bytes; longer settings are clamped to it.
  localparam logic [6:0] MAX_ROW_BYTES = 7'd64;
  // Bytes per scanline in one bank of video memory.
  localparam int LINE_BYTES = 80;

  // Register values that the write generator needs.
  typedef struct packed {
    logic [8:0] dest_x;
    logic [7:0] dest_y;
    logic       use_mask;
  } cfg_t;

  // One accepted sprite byte with the context that it was taken in.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [7:0] mask_byte;
    logic [7:0] prev_pixels;
    logic [7:0] prev_opacity;
    logic [6:0] column;
    logic [7:0] row;
    logic [6:0] right_column;
    logic       row_end;
    logic       sprite_end;
  } stage_t;

  // One video memory write.
  typedef struct packed {
    logic [13:0] address;
    logic [7:0]  write_data;
    logic [7:0]  write_bits;
    logic        last;
  } write_t;

endpackage

// ===== rtl/msb_cfg_if.sv =====
// Configuration write channel of the sprite blitter.
`timescale 1ns / 1ps

interface msb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_index;
  logic [8:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== rtl/msb_item_if.sv =====
// Sprite byte channel: packed pixels with their mask.
`timescale 1ns / 1ps

interface msb_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic [7:0] mask_byte;

  modport source (output valid, output pixel_byte, output mask_byte, input ready);
  modport sink (input valid, input pixel_byte, input mask_byte, output ready);
endinterface

// ===== rtl/msb_write_if.sv =====
// Video memory write channel of the sprite blitter.
`timescale 1ns / 1ps

interface msb_write_if;
  logic        valid;
  logic        ready;
  logic [13:0] address;
  logic [7:0]  write_data;
  logic [7:0]  write_bits;
  logic        last;

  modport source (output valid, output address, output write_data, output write_bits,
                  output last, input ready);
  modport sink (input valid, input address, input write_data, input write_bits,
                input last, output ready);
endinterface

// ===== rtl/msb_write_gen.sv =====
// Builds the address, data and bit enables of one write from a staged sprite byte.
`timescale 1ns / 1ps

module msb_write_gen (
  input  msb_pkg::cfg_t   cfg,
  input  msb_pkg::stage_t stage,
  input  logic            second,
  output msb_pkg::write_t wr
);
  import msb_pkg::*;

  logic [2:0]  rs;
  logic [7:0]  pix_hi;
  logic [7:0]  opa_hi;
  logic [15:0] mid_data;
  logic [15:0] mid_bits;
  logic [15:0] open_bits;
  logic [15:0] right_data;
  logic [15:0] right_bits;
  logic [15:0] right_open;
  logic [6:0]  col;
  logic [8:0]  y;
  logic [14:0] line_offset;

  // Right shift in bits for the pixel offset within a byte.
  assign rs = {cfg.dest_x[1:0], 1'b0};

  // The first byte of a row has no predecessor to join with.
  assign pix_hi = (stage.column == 7'd0) ? 8'h00 : stage.prev_pixels;
  assign opa_hi = (stage.column == 7'd0) ? 8'h00 : stage.prev_opacity;

  // Left or middle write: previous byte's spill joined with this byte.
  assign mid_data  = {pix_hi, stage.pixel_byte} >> rs;
  assign mid_bits  = {opa_hi, stage.mask_byte} >> rs;
  assign open_bits = {((stage.column == 7'd0) ? 8'h00 : 8'hFF), 8'hFF} >> rs;

  // Right write: the bits of the last byte pushed past its column.
  assign right_data = {stage.pixel_byte, 8'h00} >> rs;
  assign right_bits = {stage.mask_byte, 8'h00} >> rs;
  assign right_open = {8'hFF, 8'h00} >> rs;

  // Interlaced address: bank from row parity, then half row times line length.
  assign col         = second ? stage.right_column : stage.column;
  assign y           = {1'b0, cfg.dest_y} + {1'b0, stage.row};
  assign line_offset = 15'(y[8:1]) * 15'(LINE_BYTES);

  always_comb begin
    wr.address = {y[0], 13'd0} + line_offset[13:0] + 14'(cfg.dest_x[8:2]) + 14'(col);
    if (second) begin
      wr.write_data = right_data[7:0];
      wr.write_bits = cfg.use_mask ? right_bits[7:0] : right_open[7:0];
      wr.last       = stage.sprite_end;
    end else begin
      wr.write_data = mid_data[7:0];
      wr.write_bits = cfg.use_mask ? mid_bits[7:0] : open_bits[7:0];
      wr.last       = 1'b0;
    end
  end

endmodule

// ===== rtl/masked_sprite_blit_2bpp.sv =====
// Top level of the masked 2-bit-per-pixel sprite blitter.
//
//   Channel   Direction  Carries
//   cfg       in         reg_index, reg_data (register writes)
//   sprite    in         pixel_byte, mask_byte (one sprite byte per item)
//   writes    out        address, write_data, write_bits, last
//
// A byte is taken into a staging register and its write is then loaded into the
// output register. A byte that ends a row gives two writes, its own and then the
// right write, and holds the staging register until the right write is loaded.
// Reset is synchronous; it restores the register defaults and clears the row
// and column counters. Stalls on the write channel back up into the staging
// register; the configuration port never stalls.
`timescale 1ns / 1ps

module masked_sprite_blit_2bpp (
  input  logic         clk,
  input  logic         rst,
  msb_cfg_if.sink      cfg,
  msb_item_if.sink     sprite,
  msb_write_if.source  writes
);
  import msb_pkg::*;

  logic [8:0]  dest_x;
  logic [7:0]  dest_y;
  logic [6:0]  row_bytes;
  logic [7:0]  row_count;
  logic        use_mask;
  logic [7:0]  prev_pixels;
  logic [7:0]  prev_opacity;
  logic [6:0]  column_index;
  logic [7:0]  row_index;
  logic [6:0]  rb_eff;
  logic [7:0]  rc_eff;
  logic        row_end;
  logic        sprite_end;
  logic        in_accept;
  stage_t      stage;
  logic        stage_valid;
  logic        stage_second;
  logic        stage_done;
  cfg_t        cfg_view;
  write_t      wr;
  write_t      out_reg;
  logic        out_valid;
  logic        out_load;

  // Configuration registers.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_x    <= 9'd0;
      dest_y    <= 8'd0;
      row_bytes <= 7'd1;
      row_count <= 8'd1;
      use_mask  <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_DEST_X:    dest_x    <= cfg.reg_data;
        REG_DEST_Y:    dest_y    <= cfg.reg_data[7:0];
        REG_ROW_BYTES: row_bytes <= cfg.reg_data[6:0];
        REG_ROW_COUNT: row_count <= cfg.reg_data[7:0];
        REG_USE_MASK:  use_mask  <= cfg.reg_data[0];
        default: ;
      endcase
    end
  end

  // Effective row length and row count, with zero read as one and the length clamped to MAX_ROW_BYTES.
  always_comb begin
    if (row_bytes == 7'd0) begin
      rb_eff = 7'd1;
    end else if (row_bytes > MAX_ROW_BYTES) begin
      rb_eff = MAX_ROW_BYTES;
    end else begin
      rb_eff = row_bytes;
    end
    rc_eff     = (row_count == 8'd0) ? 8'd1 : row_count;
    row_end    = ({1'b0, column_index} + 8'd1) >= {1'b0, rb_eff};
    sprite_end = row_end && (({1'b0, row_index} + 9'd1) >= {1'b0, rc_eff});
  end

  // Handshake between staging and output registers.
  assign out_load     = stage_valid && (!out_valid || writes.ready);
  assign stage_done   = out_load && (stage_second || !stage.row_end);
  assign sprite.ready = !stage_valid || stage_done;
  assign in_accept    = sprite.valid && sprite.ready;

  // Position counters and the previous byte pair.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pixels  <= 8'd0;
      prev_opacity <= 8'd0;
      column_index <= 7'd0;
      row_index    <= 8'd0;
    end else if (in_accept) begin
      prev_pixels  <= sprite.pixel_byte;
      prev_opacity <= sprite.mask_byte;
      if (row_end) begin
        column_index <= 7'd0;
        row_index    <= sprite_end ? 8'd0 : row_index + 8'd1;
      end else begin
        column_index <= column_index + 7'd1;
      end
    end
  end

  // Staging register control: second marks the right write of a row.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      stage_second <= 1'b0;
    end else if (in_accept) begin
      stage_valid  <= 1'b1;
      stage_second <= 1'b0;
    end else if (stage_done) begin
      stage_valid  <= 1'b0;
      stage_second <= 1'b0;
    end else if (out_load) begin
      stage_second <= 1'b1;
    end
  end

  // Staging register payload.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage.pixel_byte   <= sprite.pixel_byte;
      stage.mask_byte    <= sprite.mask_byte;
      stage.prev_pixels  <= prev_pixels;
      stage.prev_opacity <= prev_opacity;
      stage.column       <= column_index;
      stage.row          <= row_index;
      stage.right_column <= rb_eff;
      stage.row_end      <= row_end;
      stage.sprite_end   <= sprite_end;
    end
  end

  // Write generation.
  assign cfg_view.dest_x   = dest_x;
  assign cfg_view.dest_y   = dest_y;
  assign cfg_view.use_mask = use_mask;

  msb_write_gen u_write_gen (
    .cfg    (cfg_view),
    .stage  (stage),
    .second (stage_second),
    .wr     (wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (writes.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= wr;
    end
  end

  assign writes.valid      = out_valid;
  assign writes.address    = out_reg.address;
  assign writes.write_data = out_reg.write_data;
  assign writes.write_bits = out_reg.write_bits;
  assign writes.last       = out_reg.last;

`ifndef SYNTHESIS
  // The right-write phase only exists for a staged byte that ends its row.
  a_second_needs_row_end: assert property (@(posedge clk) disable iff (rst)
    stage_second |-> (stage_valid && stage.row_end))
    else $error("right write phase without a row-ending byte");

  // The sprite end is flagged only on a right write.
  a_last_on_right_write: assert property (@(posedge clk) disable iff (rst)
    (out_load && wr.last) |-> stage_second)
    else $error("last flag on a left or middle write");

  // Reset empties both the staging and output registers.
  a_reset_empties: assert property (@(posedge clk)
    rst |=> (!stage_valid && !out_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== bench/masked_sprite_blit_2bpp_tb.sv =====
// Self-checking testbench for the masked 2-bit-per-pixel sprite blitter.
`timescale 1ns / 1ps

module masked_sprite_blit_2bpp_tb;
  import msb_pkg::*;

  localparam int ITEM_TARGET    = 1050;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 100;
  // Register index with no register behind it; writes to it must be ignored.
  localparam logic [2:0] REG_SPARE = 3'd5;

  // Predicts the video memory writes from the sprite bytes and register settings.
  class sprite_write_predictor;
    logic [8:0] dest_x;
    logic [7:0] dest_y;
    logic [6:0] row_bytes;
    logic [7:0] row_count;
    logic       use_mask;
    logic [7:0] prev_pixels;
    logic [7:0] prev_opacity;
    logic [6:0] column;
    logic [7:0] row;
    write_t     expected_writes[$];
    int         errors;

    function new();
      dest_x       = '0;
      dest_y       = '0;
      row_bytes    = 7'd1;
      row_count    = 8'd1;
      use_mask     = 1'b1;
      prev_pixels  = '0;
      prev_opacity = '0;
      column       = '0;
      row          = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [8:0] value);
      case (index)
        REG_DEST_X:    dest_x = value;
        REG_DEST_Y:    dest_y = value[7:0];
        REG_ROW_BYTES: row_bytes = value[6:0];
        REG_ROW_COUNT: row_count = value[7:0];
        REG_USE_MASK:  use_mask = value[0];
        default: ;
      endcase
    endfunction

    // Interlaced layout: odd scanlines live in the upper bank.
    function logic [13:0] address_of(int col);
      int y;
      int unsigned a;
      y = int'(dest_y) + int'(row);
      a = (y % 2) * 8192 + (y / 2) * LINE_BYTES + int'(dest_x >> 2) + col;
      return a[13:0];
    endfunction

    function void take_byte(logic [7:0] pixels, logic [7:0] opacity);
      int     rb;
      int     rc;
      int     rs;
      int     ls;
      bit     row_end;
      bit     sprite_end;
      write_t w;
      rb = (row_bytes == 0) ? 1 : int'(row_bytes);
      if (rb > int'(MAX_ROW_BYTES)) rb = int'(MAX_ROW_BYTES);
      rc = (row_count == 0) ? 1 : int'(row_count);
      rs = int'(dest_x[1:0]) * 2;
      ls = 8 - rs;
      row_end    = int'(column) + 1 >= rb;
      sprite_end = row_end && (int'(row) + 1 >= rc);

      // Left write at the start of a row, otherwise a middle write that joins
      // the spill of the previous byte with this one.
      if (column == 0) begin
        w.address    = address_of(0);
        w.write_data = pixels >> rs;
        w.write_bits = use_mask ? (opacity >> rs) : (8'hFF >> rs);
      end else begin
        w.address    = address_of(int'(column));
        w.write_data = (prev_pixels << ls) | (pixels >> rs);
        w.write_bits = use_mask ? ((prev_opacity << ls) | (opacity >> rs)) : 8'hFF;
      end
      w.last = 1'b0;
      expected_writes.push_back(w);

      // The right write carries what the last byte of the row pushed out.
      if (row_end) begin
        w.address    = address_of(rb);
        w.write_data = pixels << ls;
        w.write_bits = use_mask ? (opacity << ls) : (8'hFF << ls);
        w.last       = sprite_end;
        expected_writes.push_back(w);
      end

      prev_pixels  = pixels;
      prev_opacity = opacity;
      if (row_end) begin
        column = '0;
        row    = sprite_end ? 8'd0 : row + 8'd1;
      end else begin
        column = column + 7'd1;
      end
    endfunction

    function void compare_field(string field, logic [15:0] expected, logic [15:0] actual);
      if (expected !== actual) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, expected, actual);
      end
    endfunction

    function void check_write(write_t got);
      write_t exp;
      if (expected_writes.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t ns: unexpected write, expected none, got address 0x%0h data 0x%0h",
                   $time, got.address, got.write_data);
      end else begin
        exp = expected_writes.pop_front();
        compare_field("address", 16'(exp.address), 16'(got.address));
        compare_field("write_data", 16'(exp.write_data), 16'(got.write_data));
        compare_field("write_bits", 16'(exp.write_bits), 16'(got.write_bits));
        compare_field("last", 16'(exp.last), 16'(got.last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  msb_cfg_if   cfg_bus ();
  msb_item_if  sprite_bus ();
  msb_write_if write_bus ();

  masked_sprite_blit_2bpp i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .sprite (sprite_bus),
    .writes (write_bus)
  );

  sprite_write_predictor predictor = new();

  int in_gap_max  = 0;
  int out_gap_max = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  int bytes_sent  = 0;

  // Clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Write channel back-pressure: after each accepted item, hold ready low for
  // a drawn number of cycles.
  always @(posedge clk) begin
    if (rst) begin
      write_bus.ready <= 1'b0;
      stall_left = 0;
    end else if (write_bus.valid && write_bus.ready) begin
      stall_left = $urandom_range(0, out_gap_max);
      if (stall_left != 0) write_bus.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) write_bus.ready <= 1'b1;
    end else begin
      write_bus.ready <= 1'b1;
    end
  end

  // Observe every handshake and feed the predictor.
  always @(posedge clk) begin
    write_t got;
    if (!rst) begin
      if (write_bus.valid && write_bus.ready) begin
        got.address    = write_bus.address;
        got.write_data = write_bus.write_data;
        got.write_bits = write_bus.write_bits;
        got.last       = write_bus.last;
        predictor.check_write(got);
      end
      if (cfg_bus.valid && cfg_bus.ready)
        predictor.set_reg(cfg_bus.reg_index, cfg_bus.reg_data);
      if (sprite_bus.valid && sprite_bus.ready)
        predictor.take_byte(sprite_bus.pixel_byte, sprite_bus.mask_byte);
    end
  end

  // Watchdog: end the run when no channel has moved an item for too long.
  always @(posedge clk) begin
    if (rst || (write_bus.valid && write_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (sprite_bus.valid && sprite_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL masked_sprite_blit_2bpp");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] index, input logic [8:0] value);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= index;
    cfg_bus.reg_data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  // Write all five registers back to back, then release the channel.
  task automatic configure(input logic [8:0] x, input logic [7:0] y, input logic [6:0] rb,
                           input logic [7:0] rc, input logic um);
    write_reg(REG_DEST_X, x);
    write_reg(REG_DEST_Y, {1'b0, y});
    write_reg(REG_ROW_BYTES, {2'b00, rb});
    write_reg(REG_ROW_COUNT, {1'b0, rc});
    write_reg(REG_USE_MASK, {8'h00, um});
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one sprite byte after a drawn gap; valid stays high across
  // back-to-back items.
  task automatic send_byte(input logic [7:0] pixels, input logic [7:0] opacity);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      sprite_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sprite_bus.valid      <= 1'b1;
    sprite_bus.pixel_byte <= pixels;
    sprite_bus.mask_byte  <= opacity;
    do @(posedge clk); while (!sprite_bus.ready);
    bytes_sent++;
  endtask

  // Wait until every predicted write has arrived and the pipeline has emptied.
  task automatic wait_idle();
    @(posedge clk);
    while (predictor.expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [8:0] x;
    logic [7:0] y;
    logic [6:0] rb;
    logic [7:0] rc;
    logic [7:0] opacity;
    logic       um;
    int         n;
    int         phase;

    rst                   = 1'b1;
    cfg_bus.valid         = 1'b0;
    cfg_bus.reg_index     = REG_DEST_X;
    cfg_bus.reg_data      = '0;
    sprite_bus.valid      = 1'b0;
    sprite_bus.pixel_byte = '0;
    sprite_bus.mask_byte  = '0;
    write_bus.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults after reset: single-byte sprite at the origin, masked.
    send_byte(8'hFF, 8'hFF);
    send_byte(8'h00, 8'h00);
    sprite_bus.valid <= 1'b0;
    wait_idle();

    // Largest pixel offset, bottom scanline, two rows of two bytes.
    configure(9'd3, 8'd199, 7'd2, 8'd2, 1'b1);
    send_byte(8'hAA, 8'hF0);
    send_byte(8'h55, 8'h0F);
    send_byte(8'hFF, 8'h00);
    send_byte(8'h00, 8'hFF);
    sprite_bus.valid <= 1'b0;
    wait_idle();

    // Right edge, highest scanline, opaque writes with the mask ignored.
    configure(9'd319, 8'd255, 7'd3, 8'd1, 1'b0);
    send_byte(8'h1B, 8'h00);
    send_byte(8'hE4, 8'h5A);
    send_byte(8'hFF, 8'hA5);
    sprite_bus.valid <= 1'b0;
    wait_idle();

    // Zero sizes act as one; the spare index must leave everything alone.
    configure(9'd2, 8'd0, 7'd0, 8'd0, 1'b1);
    write_reg(REG_SPARE, 9'h1FF);
    cfg_bus.valid <= 1'b0;
    send_byte(8'hC3, 8'h3C);
    send_byte(8'h81, 8'h7E);
    sprite_bus.valid <= 1'b0;
    wait_idle();

    // Full-width dest_x; the second sprite's address wraps past the top of memory
    // and, with no pixel offset, its right write has no enabled bits.
    configure(9'd511, 8'd254, 7'd1, 8'd3, 1'b0);
    send_byte(8'h96, 8'h69);
    sprite_bus.valid <= 1'b0;
    wait_idle();
    configure(9'd508, 8'd255, 7'd1, 8'd3, 1'b1);
    send_byte(8'h69, 8'h96);
    sprite_bus.valid <= 1'b0;
    wait_idle();

    // Oversized row cut short mid-row: the column is then past the new bound.
    configure(9'd1, 8'd10, 7'd127, 8'd2, 1'b1);
    send_byte(8'h12, 8'hFE);
    send_byte(8'h34, 8'hDC);
    send_byte(8'h56, 8'hBA);
    sprite_bus.valid <= 1'b0;
    wait_idle();
    write_reg(REG_ROW_BYTES, 9'd2);
    cfg_bus.valid <= 1'b0;
    send_byte(8'h78, 8'h98);
    send_byte(8'h9A, 8'h76);
    sprite_bus.valid <= 1'b0;
    wait_idle();

    // Random phases: each draws a fresh setting and a burst of sprite bytes.
    // Most sprites are small so that sprites complete often.
    phase = 0;
    while (bytes_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       x = 9'd0;
        1:       x = 9'd319;
        2:       x = 9'($urandom_range(320, 511));
        default: x = 9'($urandom_range(0, 319));
      endcase
      case ($urandom_range(0, 7))
        0:       y = 8'd0;
        1:       y = 8'd199;
        2:       y = 8'd255;
        default: y = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 15))
        0:       rb = 7'd0;
        1:       rb = 7'd64;
        2:       rb = 7'($urandom_range(65, 127));
        3:       rb = 7'($urandom_range(9, 63));
        default: rb = 7'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       rc = 8'd0;
        1:       rc = 8'd200;
        2:       rc = 8'd255;
        default: rc = 8'($urandom_range(1, 6));
      endcase
      um = 1'($urandom_range(0, 1));
      // The first two phases always cover a full-width and an oversized row.
      if (phase == 0) rb = 7'd64;
      if (phase == 1) rb = 7'd100;
      if (phase < 2) rc = 8'd1;

      n = (rb == 0 || rb <= 8) ? $urandom_range(10, 60) : $urandom_range(70, 140);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 7;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;

      configure(x, y, rb, rc, um);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0:       opacity = 8'h00;
          1:       opacity = 8'hFF;
          default: opacity = 8'($urandom_range(0, 255));
        endcase
        send_byte(8'($urandom_range(0, 255)), opacity);
      end
      sprite_bus.valid <= 1'b0;
      wait_idle();
      phase++;
    end

    repeat (16) @(posedge clk);
    if (predictor.errors == 0 && predictor.expected_writes.size() == 0) begin
      $display("PASS masked_sprite_blit_2bpp");
    end else begin
      $display("FAIL masked_sprite_blit_2bpp");
    end
    $finish;
  end

endmodule
